>>> hdl/fpn_pkg.sv
// ----------------------------------------------------------------------------
// Frame peak normalizer package
// Shared widths, constants and state types for the frame peak normalizer.
// ----------------------------------------------------------------------------
package fpn_pkg;

   // Field widths.
   localparam int SampleW = 16;
   localparam int OutW    = 17;
   localparam int CfgW    = 9;

   // Frame length after reset and the default storage depth per bank.
   localparam logic [CfgW-1:0] CfgLengthReset  = 9'd256;
   localparam int              FrameMaxDefault = 256;

   // Q1.15 result: fraction bits, and the magnitude that stands for +1.0.
   localparam int                 QFracBits = 15;
   localparam logic [SampleW-1:0] UnitMag   = 16'h8000;

   // Top-level sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_FETCH  = 3'b010,
      ST_DIVIDE = 3'b100
   } top_state_type;

   // Serial divider states.
   typedef enum logic [1:0] {
      DIV_IDLE = 2'b01,
      DIV_RUN  = 2'b10
   } div_state_type;

endpackage

>>> hdl/frame_peak_normalizer_top.sv
// ----------------------------------------------------------------------------
// Frame peak normalizer top level
// Two-bank frame store, peak tracking and serial normalization of the
// previous frame, one result per request once a full frame is held.
// ----------------------------------------------------------------------------
// Each request stores its sample in the loading bank and, once a complete
// frame is held, returns the sample at the same position of the held frame
// divided by that frame's peak magnitude as a Q1.15 value (32768 is +1.0),
// with rsp_frame_end marking the frame's last result. Requests of the first
// frame produce no response and are taken one per cycle. A request that
// produces a response keeps the block busy to accept it and read the held
// bank, to start the divider, for the 15 steps of the one-bit-per-cycle
// restoring divider and to hand the result to the output register. A zero
// peak, or a held sample at or above the peak magnitude, skips the divider
// steps. While the output register holds a stalled response, the finished
// result waits in the divider and the block stays busy for as long as that
// stall lasts. The output register holds a waiting response while the next
// request is taken. The sample store is not cleared at reset; a frame length
// that grows between frames reads positions the held frame never wrote.
module frame_peak_normalizer_top #(
   parameter int FRAME_MAX = fpn_pkg::FrameMaxDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fpn_pkg::SampleW-1:0]  req_sample,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fpn_pkg::OutW-1:0]     rsp_normalized_sample,
   output logic                                rsp_frame_end,
   // Frame length register.
   input  logic                                csr_write_en,
   input  logic [fpn_pkg::CfgW-1:0]            csr_write_data
);
   import fpn_pkg::*;

   localparam int PosW  = $clog2(FRAME_MAX);
   localparam int AddrW = PosW + 1;
   localparam int CmpW  = (PosW + 1 > CfgW) ? PosW + 1 : CfgW;

   top_state_type          state_ff, state_in;
   logic [CfgW-1:0]        frame_length_ff;
   logic [PosW-1:0]        write_pos_ff, write_pos_in;
   logic                   bank_ff, bank_in;
   logic                   frame_ready_ff, frame_ready_in;
   logic [SampleW-1:0]     loading_peak_ff, loading_peak_in;
   logic [SampleW-1:0]     held_peak_ff, held_peak_in;
   logic [SampleW-1:0]     div_peak_ff;
   logic                   pend_end_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [OutW-1:0] rsp_sample_ff;
   logic                   rsp_end_ff;

   logic                   accept;
   logic                   out_free;
   logic                   load_out;
   logic [CmpW-1:0]        len_ext;
   logic [CmpW-1:0]        eff_len;
   logic [CmpW-1:0]        pos_next;
   logic                   last;
   logic [SampleW-1:0]     req_bits;
   logic [SampleW-1:0]     req_mag;
   logic [SampleW-1:0]     new_peak;
   logic signed [SampleW-1:0] held_sample;
   logic                   div_valid;
   logic signed [OutW-1:0] div_result;

   // Frame length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= CfgLengthReset;
      end else if (csr_write_en) begin
         frame_length_ff <= csr_write_data;
      end
   end

   // Effective length: zero acts as one, anything above the depth as the depth.
   assign len_ext = CmpW'(frame_length_ff);
   always_comb begin
      if (len_ext == '0) begin
         eff_len = CmpW'(1);
      end else if (len_ext > CmpW'(FRAME_MAX)) begin
         eff_len = CmpW'(FRAME_MAX);
      end else begin
         eff_len = len_ext;
      end
   end
   assign pos_next = CmpW'(write_pos_ff) + 1'b1;
   assign last     = (pos_next >= eff_len);

   // Peak magnitude of the loading frame including this request.
   assign req_bits = req_sample;
   assign req_mag  = req_bits[SampleW-1] ? (~req_bits + 1'b1) : req_bits;
   assign new_peak = (req_mag > loading_peak_ff) ? req_mag : loading_peak_ff;

   // Handshakes.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == ST_DIVIDE) && div_valid && out_free;

   // Sequencer and frame bookkeeping.
   always_comb begin
      state_in        = state_ff;
      write_pos_in    = write_pos_ff;
      bank_in         = bank_ff;
      frame_ready_in  = frame_ready_ff;
      loading_peak_in = loading_peak_ff;
      held_peak_in    = held_peak_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (frame_ready_ff) begin
                  state_in = ST_FETCH;
               end
               if (last) begin
                  held_peak_in    = new_peak;
                  loading_peak_in = '0;
                  write_pos_in    = '0;
                  bank_in         = ~bank_ff;
                  frame_ready_in  = 1'b1;
               end else begin
                  loading_peak_in = new_peak;
                  write_pos_in    = write_pos_ff + 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         write_pos_ff    <= '0;
         bank_ff         <= 1'b0;
         frame_ready_ff  <= 1'b0;
         loading_peak_ff <= '0;
         held_peak_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         write_pos_ff    <= write_pos_in;
         bank_ff         <= bank_in;
         frame_ready_ff  <= frame_ready_in;
         loading_peak_ff <= loading_peak_in;
         held_peak_ff    <= held_peak_in;
      end
   end

   // Divisor and frame-end flag of the request in flight.
   always_ff @(posedge clock) begin
      if (accept) begin
         div_peak_ff <= held_peak_ff;
         pend_end_ff <= last;
      end
   end

   // Sample memory: the loading bank is written while the held bank is read.
   fpn_sample_store #(
      .AddrW (AddrW)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({bank_ff, write_pos_ff}),
      .wr_data (req_sample),
      .rd_en   (accept),
      .rd_addr ({~bank_ff, write_pos_ff}),
      .rd_data (held_sample)
   );

   // Bit-serial normalization by the held peak.
   fpn_serial_div u_div (
      .clock           (clock),
      .reset           (reset),
      .start           (state_ff == ST_FETCH),
      .dividend_sample (held_sample),
      .divisor_peak    (div_peak_ff),
      .result_valid    (div_valid),
      .result          (div_result)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_sample_ff <= div_result;
         rsp_end_ff    <= pend_end_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_normalized_sample = rsp_sample_ff;
   assign rsp_frame_end         = rsp_end_ff;

endmodule

>>> hdl/fpn_sample_store.sv
// ----------------------------------------------------------------------------
// Frame peak normalizer sample store
// Two-bank sample memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fpn_sample_store #(
   parameter int AddrW = 9
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AddrW-1:0]                    wr_addr,
   input  logic signed [fpn_pkg::SampleW-1:0]  wr_data,
   input  logic                                rd_en,
   input  logic [AddrW-1:0]                    rd_addr,
   output logic signed [fpn_pkg::SampleW-1:0]  rd_data
);
   import fpn_pkg::*;

   localparam int Depth = 1 << AddrW;

   logic signed [SampleW-1:0] mem [Depth];
   logic signed [SampleW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/fpn_serial_div.sv
// ----------------------------------------------------------------------------
// Frame peak normalizer serial divider
// Restoring divider that forms |sample| * 32768 / peak one quotient bit per
// cycle, clamps at +1.0, gives zero for a zero peak and restores the sample's sign.
// ----------------------------------------------------------------------------
module fpn_serial_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [fpn_pkg::SampleW-1:0]  dividend_sample,
   input  logic [fpn_pkg::SampleW-1:0]         divisor_peak,
   output logic                                result_valid,
   output logic signed [fpn_pkg::OutW-1:0]     result
);
   import fpn_pkg::*;

   localparam int CntW = $clog2(QFracBits);

   div_state_type       state_ff, state_in;
   logic [SampleW-1:0]  rem_ff, rem_in;
   logic [SampleW-1:0]  quot_ff, quot_in;
   logic [SampleW-1:0]  peak_ff, peak_in;
   logic                neg_ff, neg_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                valid_ff, valid_in;

   logic [SampleW-1:0]  sample_bits;
   logic [SampleW-1:0]  sample_mag;
   logic [SampleW-1:0]  rem_shift;
   logic [SampleW-1:0]  rem_sub;
   logic                take;
   logic [OutW-1:0]     quot_ext;

   // Magnitude of the incoming sample; the most negative code maps to 32768.
   assign sample_bits = dividend_sample;
   assign sample_mag  = sample_bits[SampleW-1] ? (~sample_bits + 1'b1) : sample_bits;

   // One restoring step: the remainder stays below the peak, so it never
   // loses its top bit when shifted.
   assign rem_shift = {rem_ff[SampleW-2:0], 1'b0};
   assign rem_sub   = rem_shift - peak_ff;
   assign take      = (rem_shift >= peak_ff);

   // Sequencing of the division.
   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      peak_in  = peak_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               peak_in = divisor_peak;
               neg_in  = sample_bits[SampleW-1];
               if (divisor_peak == '0) begin
                  // A silent frame normalizes to zero.
                  quot_in  = '0;
                  valid_in = 1'b1;
               end else if (sample_mag >= divisor_peak) begin
                  // The quotient reaches +1.0 or beyond and is clamped.
                  quot_in  = UnitMag;
                  valid_in = 1'b1;
               end else begin
                  rem_in   = sample_mag;
                  quot_in  = '0;
                  cnt_in   = CntW'(QFracBits - 1);
                  valid_in = 1'b0;
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            rem_in  = take ? rem_sub : rem_shift;
            quot_in = {quot_ff[SampleW-2:0], take};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               valid_in = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      peak_ff <= peak_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
   end

   // Apply the sample's sign to the quotient magnitude.
   assign quot_ext     = {1'b0, quot_ff};
   assign result       = neg_ff ? $signed(~quot_ext + 1'b1) : $signed(quot_ext);
   assign result_valid = valid_ff;

endmodule

>>> hdl/fpn_checker.sv
// ----------------------------------------------------------------------------
// Frame peak normalizer checker
// Port-level assertions on the frame peak normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module fpn_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic signed [fpn_pkg::SampleW-1:0]  req_sample,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [fpn_pkg::OutW-1:0]     rsp_normalized_sample,
   input logic                                rsp_frame_end
);
   import fpn_pkg::*;

   // A stalled request stays valid and keeps its sample.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_sample))
      else $error("request changed while stalled");

   // A stalled response stays valid.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_normalized_sample) && $stable(rsp_frame_end))
      else $error("response payload changed while stalled");

   // Normalized samples never exceed +/-1.0 in Q1.15.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normalized_sample <= 17'sd32768) &&
                    (rsp_normalized_sample >= -17'sd32768))
      else $error("normalized sample out of range");

   // A new response is only produced while the request side was held off
   // for the division.
   a_rsp_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a division in progress");

endmodule

bind frame_peak_normalizer_top fpn_checker u_fpn_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .req_sample            (req_sample),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_normalized_sample (rsp_normalized_sample),
   .rsp_frame_end         (rsp_frame_end)
);

>>> sim/frame_peak_normalizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame peak normalizer checker
// Watches the request, response and frame length ports of the normalizer.
// It keeps its own two-bank frame store and peak tracking, and compares every
// response with the normalized sample that it predicts.
// ----------------------------------------------------------------------------
module frame_peak_normalizer_checker #(
   parameter int FRAME_MAX = fpn_pkg::FrameMaxDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [fpn_pkg::SampleW-1:0]  req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [fpn_pkg::OutW-1:0]     rsp_normalized_sample,
   input  logic                                rsp_frame_end,
   input  logic                                csr_write_en,
   input  logic [fpn_pkg::CfgW-1:0]            csr_write_data,
   output int                                  pending_count,
   output int                                  mismatch_count
);
   import fpn_pkg::*;

   typedef struct packed {
      logic signed [OutW-1:0] normalized;
      logic                   frame_end;
   } norm_result_type;

   // Normalized samples still owed by the block, oldest first.
   norm_result_type awaited_results [$];

   // Mirror of the block's frame banks and framing state.
   logic signed [SampleW-1:0] frame_store [0:2*FRAME_MAX-1];
   logic [SampleW:0]          loading_peak;
   logic [SampleW:0]          held_peak;
   int                        write_pos;
   logic                      load_bank;
   logic                      held_valid;
   logic [CfgW-1:0]           length_reg;
   int                        fail_total = 0;

   // Store one request's sample and queue the held-frame sample it releases.
   task automatic normalize_held_sample(input logic signed [SampleW-1:0] sample);
      int                        frame_len;
      int                        pos;
      logic                      last;
      logic signed [SampleW-1:0] held_sample;
      logic [SampleW:0]          sample_mag;
      logic [SampleW:0]          held_mag;
      logic [31:0]               quotient;
      norm_result_type           result;
      frame_len = (length_reg == 0) ? 1 : (length_reg > FRAME_MAX) ? FRAME_MAX : length_reg;
      pos = (write_pos >= FRAME_MAX) ? FRAME_MAX - 1 : write_pos;
      last = (pos + 1 >= frame_len);
      sample_mag = sample[SampleW-1] ? -{1'b1, sample} : {1'b0, sample};

      // The held frame sits in the bank that is not being loaded.
      if (held_valid) begin
         held_sample = frame_store[(load_bank ? 0 : FRAME_MAX) + pos];
         held_mag = held_sample[SampleW-1] ? -{1'b1, held_sample} : {1'b0, held_sample};
         quotient = '0;
         if (held_peak != 0) begin
            quotient = ({15'b0, held_mag} << QFracBits) / {15'b0, held_peak};
            if (quotient > UnitMag) begin
               quotient = 32'(UnitMag);
            end
         end
         result.normalized = held_sample[SampleW-1] ? -quotient[OutW-1:0] : quotient[OutW-1:0];
         result.frame_end = last;
         awaited_results.push_back(result);
      end

      // Load the new sample and close the frame on its last position.
      frame_store[(load_bank ? FRAME_MAX : 0) + pos] = sample;
      if (sample_mag > loading_peak) begin
         loading_peak = sample_mag;
      end
      if (last) begin
         held_peak = loading_peak;
         loading_peak = '0;
         write_pos = 0;
         load_bank = !load_bank;
         held_valid = 1'b1;
      end else begin
         write_pos = pos + 1;
      end
   endtask

   // Follow every handshake at the clock edge and compare responses in order.
   always @(posedge clock) begin
      norm_result_type oldest;
      if (reset) begin
         loading_peak = '0;
         held_peak = '0;
         write_pos = 0;
         load_bank = 1'b0;
         held_valid = 1'b0;
         length_reg = CfgLengthReset;
         awaited_results.delete();
      end else begin
         if (csr_write_en) begin
            length_reg = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: response with none awaited: normalized_sample %0d, frame_end %0b",
                        $time, rsp_normalized_sample, rsp_frame_end);
               fail_total++;
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_normalized_sample !== oldest.normalized) begin
                  $display("%0t: normalized_sample expected %0d, actual %0d",
                           $time, oldest.normalized, rsp_normalized_sample);
                  fail_total++;
               end
               if (rsp_frame_end !== oldest.frame_end) begin
                  $display("%0t: frame_end expected %0b, actual %0b",
                           $time, oldest.frame_end, rsp_frame_end);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            normalize_held_sample(req_sample);
         end
      end
      pending_count <= awaited_results.size();
      mismatch_count <= fail_total;
   end

endmodule

>>> sim/frame_peak_normalizer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame peak normalizer testbench
// Drives sample requests and frame length writes into the normalizer with
// random idle and stall cycles, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module frame_peak_normalizer_top_tb;
   import fpn_pkg::*;

   localparam int FRAME_MAX      = FrameMaxDefault;
   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int IDLE_PERCENT   = 31;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TARGET_ITEMS   = 450;
   localparam int EDGE_COUNT     = 16;

   typedef enum int {
      SRC_FULL,
      SRC_QUIET,
      SRC_SILENT,
      SRC_EXTREME
   } sample_source_type;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic signed [SampleW-1:0] req_sample     = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic signed [OutW-1:0]    rsp_normalized_sample;
   logic                      rsp_frame_end;
   logic                      csr_write_en   = 1'b0;
   logic [CfgW-1:0]           csr_write_data = '0;

   int   pending_count;
   int   mismatch_count;
   int   idle_cycles = 0;
   int   items_sent = 0;
   logic calm = 1'b0;

   // Framing as the stimulus sees it, so that a held frame is never read
   // past the positions its bank has ever been written.
   int   plan_pos = 0;
   int   plan_len = FRAME_MAX;
   logic plan_bank = 1'b0;
   logic plan_ready = 1'b0;
   int   bank_extent [2] = '{0, 0};

   frame_peak_normalizer_top #(
      .FRAME_MAX(FRAME_MAX)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample            (req_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_normalized_sample (rsp_normalized_sample),
      .rsp_frame_end         (rsp_frame_end),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data)
   );

   frame_peak_normalizer_checker #(
      .FRAME_MAX(FRAME_MAX)
   ) norm_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample            (req_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_normalized_sample (rsp_normalized_sample),
      .rsp_frame_end         (rsp_frame_end),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data),
      .pending_count         (pending_count),
      .mismatch_count        (mismatch_count)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // The response side stalls at random except during the calm stretch.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   // End the run when nothing has moved on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL frame_peak_normalizer_top");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int clamp_length(input logic [CfgW-1:0] value);
      if (value == 0) begin
         return 1;
      end
      return (value > FRAME_MAX) ? FRAME_MAX : value;
   endfunction

   // Keep a length no longer than what the held bank has ever been filled to.
   function automatic logic [CfgW-1:0] safe_length(input logic [CfgW-1:0] want);
      int held_extent;
      held_extent = bank_extent[plan_bank ^ 1'b1];
      if (plan_ready && clamp_length(want) > held_extent) begin
         return CfgW'(held_extent);
      end
      return want;
   endfunction

   function automatic logic signed [SampleW-1:0] random_sample(input sample_source_type source);
      case (source)
         SRC_QUIET: begin
            return SampleW'($signed($urandom_range(511)) - 256);
         end
         SRC_SILENT: begin
            return '0;
         end
         SRC_EXTREME: begin
            case ($urandom_range(4))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'shFFFF;
               3: return 16'sh0001;
               default: return 16'sh0000;
            endcase
         end
         default: begin
            return SampleW'($urandom);
         end
      endcase
   endfunction

   // Write the frame length while the block is idle.
   task automatic write_frame_length(input logic [CfgW-1:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      plan_len = clamp_length(value);
      @(posedge clock);
   endtask

   // Offer one request after a random idle gap and hold it until taken.
   task automatic send_request(input logic signed [SampleW-1:0] value);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (plan_pos + 1 > bank_extent[plan_bank]) begin
         bank_extent[plan_bank] = plan_pos + 1;
      end
      if (plan_pos + 1 >= plan_len) begin
         plan_pos = 0;
         plan_bank = !plan_bank;
         plan_ready = 1'b1;
      end else begin
         plan_pos++;
      end
      items_sent++;
   endtask

   // Stop requesting, collect every owed response and let the block settle.
   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic signed [SampleW-1:0] edge_value;
      logic [CfgW-1:0]           want;
      sample_source_type         source;
      int                        count;
      int                        phase;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // First frame at the longest length: field extremes, then random fill.
      // It only loads the store, so no responses come back yet.
      write_frame_length(9'h1FF);
      for (int i = 0; i < EDGE_COUNT; i++) begin
         case (i)
            0:  edge_value = 16'sh8000;
            1:  edge_value = 16'sh7FFF;
            2:  edge_value = 16'sh0000;
            3:  edge_value = 16'shFFFF;
            4:  edge_value = 16'sh0001;
            5:  edge_value = 16'sh8001;
            6:  edge_value = 16'sh4000;
            7:  edge_value = 16'shC000;
            8:  edge_value = 16'sh5555;
            9:  edge_value = 16'shAAAA;
            10: edge_value = 16'sh7FFE;
            11: edge_value = 16'sh00FF;
            12: edge_value = 16'shFF00;
            13: edge_value = 16'sh0100;
            14: edge_value = 16'sh3039;
            default: edge_value = 16'shFFFE;
         endcase
         send_request(edge_value);
      end
      while (items_sent < FRAME_MAX) begin
         send_request(random_sample(SRC_FULL));
      end
      finish_phase();

      // A short frame reads back the extremes against a full-scale peak.
      write_frame_length(9'(EDGE_COUNT));
      repeat (EDGE_COUNT) send_request(random_sample(SRC_FULL));
      finish_phase();

      // Length zero acts as one sample per frame: every nonzero sample is its
      // own peak, giving plus or minus one, and a zero sample a zero peak.
      write_frame_length('0);
      send_request(16'sh7FFF);
      send_request(16'sh8000);
      send_request(16'sh0000);
      send_request(16'sh0007);
      send_request(-16'sd3);
      send_request(16'sh0001);
      finish_phase();

      // Random phases; length writes may land mid-frame.
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         calm <= (phase >= 5 && phase < 9);
         if ($urandom_range(99) < 70) begin
            case ($urandom_range(11))
               0: want = '0;
               1: want = 9'd1;
               2: want = 9'(FRAME_MAX);
               3: want = 9'h1FF;
               4: want = 9'($urandom_range(511, FRAME_MAX + 1));
               5: want = 9'($urandom_range(64, 17));
               default: want = 9'($urandom_range(16, 2));
            endcase
            write_frame_length(safe_length(want));
         end
         case ($urandom_range(19))
            0, 1:          source = SRC_SILENT;
            2, 3, 4:       source = SRC_EXTREME;
            5, 6, 7, 8, 9: source = SRC_QUIET;
            default:       source = SRC_FULL;
         endcase
         count = $urandom_range(30, 1);
         repeat (count) send_request(random_sample(source));
         finish_phase();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("PASS frame_peak_normalizer_top");
      end else begin
         $display("FAIL frame_peak_normalizer_top");
      end
      $finish;
   end

endmodule

>>> frame_peak_normalizer_top.f
hdl/fpn_pkg.sv
hdl/fpn_sample_store.sv
hdl/fpn_serial_div.sv
hdl/frame_peak_normalizer_top.sv
hdl/fpn_checker.sv
sim/frame_peak_normalizer_checker.sv
sim/frame_peak_normalizer_top_tb.sv
